### hw/rtl/line_point_stepper_unit_macros.svh
// assertion macros for the line point stepper checker
`ifndef LINE_POINT_STEPPER_UNIT_MACROS_SVH
`define LINE_POINT_STEPPER_UNIT_MACROS_SVH

// same-cycle implication, with a caller-given disable condition
`define LPS_ASSERT_IMPL(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, with a caller-given disable condition
`define LPS_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/lps_pkg.sv
// shared constants and types for the line point stepper
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  localparam int COORD_BITS_DEF = 12;

  // request opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // line orientation and state decided at start
  typedef struct packed {
    logic axis_is_y;
    logic major_dir_down;
    logic minor_dir_down;
    logic nonzero;
  } line_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/lps_if.sv
// request and point channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface lps_req_if import lps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, output opcode, output start_x, output start_y,
                  output end_x, output end_y, input ready);
  modport sink (input valid, input opcode, input start_x, input start_y,
                input end_x, input end_y, output ready);
endinterface

interface lps_pt_if import lps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  point_valid;
  logic                  final_point;

  modport source (output valid, output point_x, output point_y,
                  output point_valid, output final_point, input ready);
  modport sink (input valid, input point_x, input point_y,
                input point_valid, input final_point, output ready);
endinterface

`default_nettype wire

### hw/rtl/lps_setup.sv
// start decode: axis choice, deltas, directions and initial error
`timescale 1ns / 1ps
`default_nettype none

module lps_setup import lps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS-1:0] major_start,
  output logic [COORD_BITS-1:0] major_stop,
  output logic [COORD_BITS-1:0] minor_start,
  output logic [COORD_BITS:0]   major_delta,
  output logic [COORD_BITS:0]   minor_delta,
  output logic [COORD_BITS+1:0] err_init,
  output line_ctl_t             ctl
);

  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  x_down;
  logic                  y_down;
  logic                  axis_y;

  always_comb begin
    x_down = end_x < start_x;
    y_down = end_y < start_y;
    adx    = x_down ? start_x - end_x : end_x - start_x;
    ady    = y_down ? start_y - end_y : end_y - start_y;
    axis_y = !(ady < adx);

    if (axis_y) begin
      major_start = start_y;
      major_stop  = end_y;
      minor_start = start_x;
      major_delta = DW'(ady);
      minor_delta = DW'(adx);
      ctl.major_dir_down = y_down;
      ctl.minor_dir_down = x_down;
    end else begin
      major_start = start_x;
      major_stop  = end_x;
      minor_start = start_y;
      major_delta = DW'(adx);
      minor_delta = DW'(ady);
      ctl.major_dir_down = x_down;
      ctl.minor_dir_down = y_down;
    end
    ctl.axis_is_y = axis_y;
    ctl.nonzero   = major_delta != '0;

    // half rounds up: falling minor axis starts one lower
    if (ctl.nonzero) begin
      err_init = EW'(major_delta) - EW'(ctl.minor_dir_down);
    end else begin
      err_init = '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lps_step.sv
// line state and per-tick error accumulator step
`timescale 1ns / 1ps
`default_nettype none

module lps_step import lps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  tick,
  input  logic [COORD_BITS-1:0] major_start,
  input  logic [COORD_BITS-1:0] major_stop_in,
  input  logic [COORD_BITS-1:0] minor_start,
  input  logic [COORD_BITS:0]   major_delta_in,
  input  logic [COORD_BITS:0]   minor_delta_in,
  input  logic [COORD_BITS+1:0] err_init,
  input  line_ctl_t             ctl_in,
  output logic [COORD_BITS-1:0] point_x,
  output logic [COORD_BITS-1:0] point_y,
  output logic                  point_valid,
  output logic                  final_point
);

  localparam int EW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] major_pos;
  logic [COORD_BITS-1:0] major_stop;
  logic [COORD_BITS-1:0] minor_pos;
  logic [EW-1:0]         error_acc;
  logic [COORD_BITS:0]   major_delta;
  logic [COORD_BITS:0]   minor_delta;
  line_ctl_t             ctl;
  logic                  line_active;

  logic [COORD_BITS-1:0] major_pos_next;
  logic [COORD_BITS-1:0] minor_pos_next;
  logic [EW-1:0]         err_sum;
  logic [EW-1:0]         twice_major;
  logic [EW-1:0]         error_acc_next;
  logic                  last;

  always_comb begin
    major_pos_next = ctl.major_dir_down ? major_pos - 1'b1 : major_pos + 1'b1;
    last           = major_pos_next == major_stop;
    err_sum        = error_acc + {minor_delta, 1'b0};
    twice_major    = {major_delta, 1'b0};
    if (err_sum >= twice_major) begin
      error_acc_next = err_sum - twice_major;
      minor_pos_next = ctl.minor_dir_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
    end else begin
      error_acc_next = err_sum;
      minor_pos_next = minor_pos;
    end

    point_valid = line_active;
    final_point = line_active && last;
    if (!line_active) begin
      point_x = '0;
      point_y = '0;
    end else if (ctl.axis_is_y) begin
      point_x = minor_pos;
      point_y = major_pos;
    end else begin
      point_x = major_pos;
      point_y = minor_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (load) begin
      line_active <= ctl_in.nonzero;
    end else if (tick && line_active && last) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      major_pos   <= major_start;
      major_stop  <= major_stop_in;
      minor_pos   <= minor_start;
      error_acc   <= err_init;
      major_delta <= major_delta_in;
      minor_delta <= minor_delta_in;
      ctl         <= ctl_in;
    end else if (tick && line_active) begin
      major_pos <= major_pos_next;
      minor_pos <= minor_pos_next;
      error_acc <= error_acc_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/line_point_stepper_unit.sv
// line point stepper top level: request register, line stepper, point register
// a tick taken into the request register has its point registered in the point register
// throughput: one request per cycle, start or tick, while points are taken
// the step is one add, a compare and a conditional subtract on the error accumulator
// reset: synchronous, clears the line (idle) and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module line_point_stepper_unit import lps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  lps_req_if.sink    req,
  lps_pt_if.source   resp
);

  // request register
  logic                  req_vld;
  logic                  req_op;
  logic [COORD_BITS-1:0] req_sx;
  logic [COORD_BITS-1:0] req_sy;
  logic [COORD_BITS-1:0] req_ex;
  logic [COORD_BITS-1:0] req_ey;

  // point register
  logic                  rsp_vld;
  logic [COORD_BITS-1:0] rsp_x;
  logic [COORD_BITS-1:0] rsp_y;
  logic                  rsp_pv;
  logic                  rsp_fin;

  // handshake control
  logic out_free;
  logic fire;
  logic load;
  logic tick;

  // start decode results
  logic [COORD_BITS-1:0] major_start;
  logic [COORD_BITS-1:0] major_stop;
  logic [COORD_BITS-1:0] minor_start;
  logic [COORD_BITS:0]   major_delta;
  logic [COORD_BITS:0]   minor_delta;
  logic [COORD_BITS+1:0] err_init;
  line_ctl_t             ctl;

  // current point from the stepper
  logic [COORD_BITS-1:0] step_x;
  logic [COORD_BITS-1:0] step_y;
  logic                  step_pv;
  logic                  step_fin;

  // a start never needs the point register, a tick needs a free slot
  assign out_free  = !rsp_vld || resp.ready;
  assign fire      = req_vld && ((req_op == OP_START) || out_free);
  assign load      = fire && (req_op == OP_START);
  assign tick      = fire && (req_op == OP_TICK);
  assign req.ready = !req_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (req.ready) begin
      req_vld <= req.valid;
    end
  end

  // request payload held until the stepper takes it
  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      req_op <= req.opcode;
      req_sx <= req.start_x;
      req_sy <= req.start_y;
      req_ex <= req.end_x;
      req_ey <= req.end_y;
    end
  end

  lps_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x     (req_sx),
    .start_y     (req_sy),
    .end_x       (req_ex),
    .end_y       (req_ey),
    .major_start (major_start),
    .major_stop  (major_stop),
    .minor_start (minor_start),
    .major_delta (major_delta),
    .minor_delta (minor_delta),
    .err_init    (err_init),
    .ctl         (ctl)
  );

  lps_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .tick           (tick),
    .major_start    (major_start),
    .major_stop_in  (major_stop),
    .minor_start    (minor_start),
    .major_delta_in (major_delta),
    .minor_delta_in (minor_delta),
    .err_init       (err_init),
    .ctl_in         (ctl),
    .point_x        (step_x),
    .point_y        (step_y),
    .point_valid    (step_pv),
    .final_point    (step_fin)
  );

  // point register: filled by a tick, emptied when the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (tick) begin
      rsp_vld <= 1'b1;
    end else if (resp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      rsp_x   <= step_x;
      rsp_y   <= step_y;
      rsp_pv  <= step_pv;
      rsp_fin <= step_fin;
    end
  end

  assign resp.valid       = rsp_vld;
  assign resp.point_x     = rsp_x;
  assign resp.point_y     = rsp_y;
  assign resp.point_valid = rsp_pv;
  assign resp.final_point = rsp_fin;

endmodule

`default_nettype wire

### hw/rtl/lps_checker.sv
// port-level checker for the line point stepper, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "line_point_stepper_unit_macros.svh"

module lps_checker import lps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  resp_valid,
  input logic                  resp_ready,
  input logic [COORD_BITS-1:0] point_x,
  input logic [COORD_BITS-1:0] point_y,
  input logic                  point_valid,
  input logic                  final_point
);

  `LPS_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !resp_valid, "point valid after reset")
  `LPS_ASSERT_IMPL(a_idle_zero, clk, rst, resp_valid && !point_valid, point_x == '0 && point_y == '0 && !final_point, "idle tick result not zero")
  `LPS_ASSERT_IMPL(a_final_valid, clk, rst, resp_valid && final_point, point_valid, "final flag on an invalid point")
  `LPS_ASSERT_NEXT(a_hold, clk, rst, resp_valid && !resp_ready, resp_valid && $stable(point_x) && $stable(point_y) && $stable(final_point), "stalled point changed")

endmodule

bind line_point_stepper_unit lps_checker #(
  .COORD_BITS (COORD_BITS)
) u_lps_checker (
  .clk         (clk),
  .rst         (rst),
  .resp_valid  (resp.valid),
  .resp_ready  (resp.ready),
  .point_x     (resp.point_x),
  .point_y     (resp.point_y),
  .point_valid (resp.point_valid),
  .final_point (resp.final_point)
);

`default_nettype wire
